// File: rtl/verb_noun_hash_table_unit_defines.svh
// Assertion macros for the hash table RTL.
`ifndef VERB_NOUN_HASH_TABLE_UNIT_DEFINES_SVH
`define VERB_NOUN_HASH_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked property that is ignored while reset is high.
`define VNHT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that is checked in every cycle, reset included.
`define VNHT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define VNHT_ASSERT(label, clk, rst, prop, msg)
`define VNHT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: rtl/vnht_pkg.sv
// Package with the sizes, codes and interface types of the verb/noun hash table.
package vnht_pkg;

   // Table geometry. BUCKETS must be a power of two.
   localparam int BUCKETS      = 64;
   localparam int POOL_ENTRIES = 256;
   localparam int BKT_W        = $clog2(BUCKETS);
   localparam int PIDX_W       = $clog2(POOL_ENTRIES);
   localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);
   localparam int KEY_W        = 16;
   localparam int ADDR_W       = 16;

   // Request action codes.
   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_LOOKUP = 1'b1
   } action_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DUP  = 2'd1,
      STATUS_FULL = 2'd2,
      STATUS_MISS = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_PROBE,
      ST_INSERT_HEAD,
      ST_INSERT_TAIL,
      ST_LINK,
      ST_DONE
   } state_type;

   // One pool slot: the key and its stored address.
   typedef struct packed {
      logic signed [KEY_W-1:0] verb;
      logic signed [KEY_W-1:0] noun;
      logic [ADDR_W-1:0]       address;
   } entry_type;

   // Chain link of a pool slot.
   typedef struct packed {
      logic              valid;
      logic [PIDX_W-1:0] index;
   } link_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       read_head;
      logic       read_next;
      logic       write_entry;
      logic       write_head;
      logic       link;
      logic       count_inc;
      logic       set_result;
      status_type result_code;
      logic       take_address;
      logic       load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_lookup;
      logic head_hit;
      logic key_match;
      logic next_hit;
      logic pool_full;
      logic rsp_stall;
   } stat_type;

endpackage

// File: rtl/verb_noun_hash_table_unit.sv
// Verb/noun hash table: one request a time; a lookup reads the bucket head, then compares the
// chain slots, one pool read per cycle, until a key match or the end of the chain sets the result.
// An insert of a new key writes the entry and the head of an empty bucket, or the entry and then a tail link.
// The next request is accepted in the cycle after the response is loaded.
// Synchronous reset clears the bucket valid bits, the fill count and the handshake state;
// no clearing pass is needed, so requests are accepted right after reset.
module verb_noun_hash_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic signed [vnht_pkg::KEY_W-1:0] req_verb_code,
   input  logic signed [vnht_pkg::KEY_W-1:0] req_noun_code,
   input  logic [vnht_pkg::ADDR_W-1:0]       req_code_address,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [vnht_pkg::ADDR_W-1:0]       rsp_found_address,
   output logic [vnht_pkg::CNT_W-1:0]        rsp_stored_count
);
   import vnht_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   vnht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table storage and compare logic.
   vnht_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_verb_code     (req_verb_code),
      .req_noun_code     (req_noun_code),
      .req_code_address  (req_code_address),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_found_address (rsp_found_address),
      .rsp_stored_count  (rsp_stored_count)
   );

endmodule

// File: rtl/vnht_ctrl.sv
// Controller state machine that sequences the chain walk and the insert.
module vnht_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  vnht_pkg::stat_type stat,
   output vnht_pkg::cmd_type  cmd
);
   import vnht_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_HEAD;
            end
         end
         ST_HEAD: begin
            // An empty bucket ends the search at once.
            if (stat.head_hit) begin
               cmd.read_head = 1'b1;
               state_in      = ST_PROBE;
            end else if (stat.is_lookup) begin
               cmd.set_result  = 1'b1;
               cmd.result_code = STATUS_MISS;
               state_in        = ST_DONE;
            end else if (stat.pool_full) begin
               cmd.set_result  = 1'b1;
               cmd.result_code = STATUS_FULL;
               state_in        = ST_DONE;
            end else begin
               state_in = ST_INSERT_HEAD;
            end
         end
         ST_PROBE: begin
            // One slot of the chain is compared per cycle.
            if (stat.key_match) begin
               cmd.set_result = 1'b1;
               if (stat.is_lookup) begin
                  cmd.result_code  = STATUS_OK;
                  cmd.take_address = 1'b1;
               end else begin
                  cmd.result_code = STATUS_DUP;
               end
               state_in = ST_DONE;
            end else if (stat.next_hit) begin
               cmd.read_next = 1'b1;
            end else if (stat.is_lookup) begin
               cmd.set_result  = 1'b1;
               cmd.result_code = STATUS_MISS;
               state_in        = ST_DONE;
            end else if (stat.pool_full) begin
               cmd.set_result  = 1'b1;
               cmd.result_code = STATUS_FULL;
               state_in        = ST_DONE;
            end else begin
               state_in = ST_INSERT_TAIL;
            end
         end
         ST_INSERT_HEAD: begin
            cmd.write_entry = 1'b1;
            cmd.write_head  = 1'b1;
            cmd.count_inc   = 1'b1;
            cmd.set_result  = 1'b1;
            cmd.result_code = STATUS_OK;
            state_in        = ST_DONE;
         end
         ST_INSERT_TAIL: begin
            cmd.write_entry = 1'b1;
            state_in        = ST_LINK;
         end
         ST_LINK: begin
            cmd.link        = 1'b1;
            cmd.count_inc   = 1'b1;
            cmd.set_result  = 1'b1;
            cmd.result_code = STATUS_OK;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            // Wait until the output register is free.
            if (!stat.rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/vnht_datapath.sv
// Datapath with the bucket heads, the entry pool, the key compare and the response register.
`include "verb_noun_hash_table_unit_defines.svh"

module vnht_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_action,
   input  logic signed [vnht_pkg::KEY_W-1:0] req_verb_code,
   input  logic signed [vnht_pkg::KEY_W-1:0] req_noun_code,
   input  logic [vnht_pkg::ADDR_W-1:0]       req_code_address,
   input  vnht_pkg::cmd_type                 cmd,
   output vnht_pkg::stat_type                stat,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [vnht_pkg::ADDR_W-1:0]       rsp_found_address,
   output logic [vnht_pkg::CNT_W-1:0]        rsp_stored_count
);
   import vnht_pkg::*;

   // Captured request.
   action_type              action_ff;
   logic signed [KEY_W-1:0] verb_ff;
   logic signed [KEY_W-1:0] noun_ff;
   logic [ADDR_W-1:0]       caddr_ff;
   logic [BKT_W-1:0]        bucket_ff;

   // Bucket heads: valid bits in flops, indexes in a memory.
   logic [BUCKETS-1:0]      head_vld_ff;
   logic [PIDX_W-1:0]       head_mem [BUCKETS];
   logic [PIDX_W-1:0]       head_rd_ff;
   logic                    head_hit_ff;

   // Entry pool and its chain links.
   entry_type               entry_mem [POOL_ENTRIES];
   link_type                next_mem [POOL_ENTRIES];
   entry_type               entry_rd_ff;
   link_type                next_rd_ff;
   logic [PIDX_W-1:0]       cur_ff;

   // Fill count, result and response registers.
   logic [CNT_W-1:0]        count_ff;
   status_type              res_status_ff;
   logic [ADDR_W-1:0]       res_addr_ff;
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [ADDR_W-1:0]       rsp_addr_ff;
   logic [CNT_W-1:0]        rsp_count_ff;

   logic [KEY_W:0]          sum_in;
   logic [KEY_W:0]          mag_in;
   logic [BKT_W-1:0]        bucket_in;
   logic [PIDX_W-1:0]       rd_addr_in;
   logic                    rd_en_in;
   logic [PIDX_W-1:0]       new_idx_in;
   logic [PIDX_W-1:0]       link_addr_in;
   link_type                link_data_in;

   // Bucket of the incoming key: magnitude of the exact sum, low bits.
   assign sum_in    = {req_verb_code[KEY_W-1], req_verb_code}
                    + {req_noun_code[KEY_W-1], req_noun_code};
   assign mag_in    = sum_in[KEY_W] ? (~sum_in + 1'b1) : sum_in;
   assign bucket_in = mag_in[BKT_W-1:0];

   // Request capture and head lookup.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff   <= action_type'(req_action);
         verb_ff     <= req_verb_code;
         noun_ff     <= req_noun_code;
         caddr_ff    <= req_code_address;
         bucket_ff   <= bucket_in;
         head_rd_ff  <= head_mem[bucket_in];
         head_hit_ff <= head_vld_ff[bucket_in];
      end
   end

   // Head index memory write.
   always_ff @(posedge clock) begin
      if (cmd.write_head) begin
         head_mem[bucket_ff] <= new_idx_in;
      end
   end

   // Head valid bits, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
      end else if (cmd.write_head) begin
         head_vld_ff[bucket_ff] <= 1'b1;
      end
   end

   // Pool read address: the bucket head or the next link of the current slot.
   assign rd_addr_in = cmd.read_head ? head_rd_ff : next_rd_ff.index;
   assign rd_en_in   = cmd.read_head | cmd.read_next;
   assign new_idx_in = count_ff[PIDX_W-1:0];

   // Pool read with registered data.
   always_ff @(posedge clock) begin
      if (rd_en_in) begin
         entry_rd_ff <= entry_mem[rd_addr_in];
         next_rd_ff  <= next_mem[rd_addr_in];
         cur_ff      <= rd_addr_in;
      end
   end

   // Entry write at the next free slot.
   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         entry_mem[new_idx_in] <= '{verb: verb_ff, noun: noun_ff, address: caddr_ff};
      end
   end

   // Link write: a new slot ends its chain; a link step hooks it to the old tail.
   assign link_addr_in = cmd.link ? cur_ff : new_idx_in;
   assign link_data_in = cmd.link ? link_type'{valid: 1'b1, index: new_idx_in}
                                  : link_type'{valid: 1'b0, index: '0};

   always_ff @(posedge clock) begin
      if (cmd.write_entry || cmd.link) begin
         next_mem[link_addr_in] <= link_data_in;
      end
   end

   // Fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.count_inc) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // Result of the current request.
   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         res_status_ff <= cmd.result_code;
         res_addr_ff   <= cmd.take_address ? entry_rd_ff.address : '0;
      end
   end

   // Response output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_address = rsp_addr_ff;
   assign rsp_stored_count  = rsp_count_ff;

   // Status to the controller.
   always_comb begin
      stat.is_lookup = (action_ff == ACT_LOOKUP);
      stat.head_hit  = head_hit_ff;
      stat.key_match = (entry_rd_ff.verb == verb_ff) && (entry_rd_ff.noun == noun_ff);
      stat.next_hit  = next_rd_ff.valid;
      stat.pool_full = (count_ff >= CNT_W'(POOL_ENTRIES));
      stat.rsp_stall = rsp_valid_ff && !rsp_ready;
   end

   // The fill count never passes the pool size.
   `VNHT_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(POOL_ENTRIES), "fill count beyond pool size")
   // A slot is written only while the pool has room.
   `VNHT_ASSERT(a_write_room, clock, reset, cmd.write_entry |-> (count_ff < CNT_W'(POOL_ENTRIES)), "entry write into a full pool")
   // A link is attached only to the tail of its chain.
   `VNHT_ASSERT(a_link_tail, clock, reset, cmd.link |-> !next_rd_ff.valid, "link written over an existing link")
   // A pending response is never overwritten.
   `VNHT_ASSERT(a_rsp_hold, clock, reset, cmd.load_rsp |-> !(rsp_valid_ff && !rsp_ready), "response overwritten before it was taken")

endmodule
